### rtl/gbn_pkg.sv
package gbn_pkg;

	localparam int SEQ_W      = 16;
	localparam int HANDLE_W   = 16;
	localparam int LEN_W      = 7;
	localparam int TMR_W      = 20;
	localparam int WIN_W      = 4;
	localparam int OUTS_W     = 4;   // outstanding count never exceeds the 4-bit window
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	localparam int RING_DEPTH_DEF  = 16;
	localparam int MAX_PAYLOAD_DEF = 80;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [WIN_W-1:0] WIN_RESET = 4'd6;
	localparam logic [TMR_W-1:0] TMO_RESET = 20'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		CMD_OFFER = 2'd0,
		CMD_ACK   = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_END   = 2'd3
	} gbn_cmd_t;

	typedef struct packed {
		gbn_cmd_t            cmd;
		logic [HANDLE_W-1:0] payload_handle;
		logic [LEN_W-1:0]    payload_length;
		logic [SEQ_W-1:0]    ack_number;
	} gbn_item_t;

	typedef struct packed {
		logic                send_valid;
		logic [SEQ_W-1:0]    send_seq;
		logic [HANDLE_W-1:0] send_handle;
		logic [LEN_W-1:0]    send_length;
		logic                is_resend;
		logic                offer_accepted;
		logic                timed_out;
		logic [SEQ_W-1:0]    window_base;
		logic                last;
	} gbn_result_t;

	// Classified word handed from front to back
	typedef struct packed {
		gbn_cmd_t            cmd;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
		logic [SEQ_W-1:0]    ack;
	} gbn_op_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} gbn_slot_t;

endpackage

### rtl/gbn_front.sv
module gbn_front #(
	parameter int MAX_PAYLOAD = gbn_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                start,
	input  gbn_pkg::gbn_item_t  item,
	input  logic                q_full,
	output logic                busy,
	output logic                push,
	output gbn_pkg::gbn_op_t    op
);
	import gbn_pkg::*;

	assign busy = q_full;
	assign push = start & ~q_full;

	// Classify: keep only the fields the command uses, clamp oversized payloads
	always_comb begin
		op = '0;
		op.cmd = item.cmd;
		case (item.cmd)
			CMD_OFFER: begin
				op.handle = item.payload_handle;
				if (32'(item.payload_length) > MAX_PAYLOAD) begin
					op.length = LEN_W'(MAX_PAYLOAD);
				end else begin
					op.length = item.payload_length;
				end
			end
			CMD_ACK: begin
				op.ack = item.ack_number;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/gbn_queue.sv
module gbn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gbn_pkg::gbn_op_t  wdata,
	input  logic              pop,
	output gbn_pkg::gbn_op_t  rdata,
	output logic              empty,
	output logic              full
);
	import gbn_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	gbn_op_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/gbn_back.sv
module gbn_back #(
	parameter int RING_DEPTH = gbn_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              q_empty,
	input  gbn_pkg::gbn_op_t                  q_data,
	output logic                              pop,
	output logic                              result_valid,
	output gbn_pkg::gbn_result_t              result
);
	import gbn_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int SUM_W = IDX_W + OUTS_W;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_WALK = 2'b10
	} gbn_state_t;

	gbn_state_t          state_q, state_d;
	logic [WIN_W-1:0]    win_q;
	logic [TMR_W-1:0]    tmo_q;
	logic [SEQ_W-1:0]    base_q, base_d;
	logic [SEQ_W-1:0]    next_q, next_d;
	logic [IDX_W-1:0]    base_idx_q, base_idx_d;
	logic [IDX_W-1:0]    next_idx_q, next_idx_d;
	logic [TMR_W-1:0]    tmr_q, tmr_d;
	logic                tmr_run_q, tmr_run_d;
	logic [OUTS_W-1:0]   walk_i_q, walk_i_d;

	gbn_slot_t           ring_mem [RING_DEPTH];
	gbn_slot_t           rd_q;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;

	gbn_result_t         res_s1, res_d;
	gbn_result_t         res_out;
	logic                vld_s1, vld_d;
	logic                mem_s1, mem_d;

	logic [SEQ_W-1:0]    outs;
	logic [SEQ_W-1:0]    ack_off;
	logic [SEQ_W-1:0]    ack_next;
	logic [OUTS_W-1:0]   ack_delta;
	logic [TMR_W-1:0]    tmr_inc;
	logic [SUM_W-1:0]    walk_sum;
	logic [SUM_W-1:0]    ack_sum;

	assign outs     = next_q - base_q;
	assign ack_off  = q_data.ack - base_q;
	assign ack_next = q_data.ack + 1'b1;
	assign ack_delta = OUTS_W'(ack_off + 1'b1);
	assign tmr_inc  = tmr_q + 1'b1;
	assign pop      = ~q_empty & (state_q == ST_RUN);

	// Ring slots of the packet being resent and of the new base after an ack: base slot plus offset, wrapped once
	always_comb begin
		walk_sum = SUM_W'(base_idx_q) + SUM_W'(walk_i_q);
		if (walk_sum >= SUM_W'(RING_DEPTH)) begin
			walk_sum = walk_sum - SUM_W'(RING_DEPTH);
		end
		ack_sum = SUM_W'(base_idx_q) + SUM_W'(ack_delta);
		if (ack_sum >= SUM_W'(RING_DEPTH)) begin
			ack_sum = ack_sum - SUM_W'(RING_DEPTH);
		end
	end

	assign rd_addr = walk_sum[IDX_W-1:0];

	always_comb begin
		state_d    = state_q;
		base_d     = base_q;
		next_d     = next_q;
		base_idx_d = base_idx_q;
		next_idx_d = next_idx_q;
		tmr_d      = tmr_q;
		tmr_run_d  = tmr_run_q;
		walk_i_d   = walk_i_q;
		res_d      = '0;
		vld_d      = 1'b0;
		mem_d      = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;

		if (state_q == ST_WALK) begin
			rd_en             = 1'b1;
			vld_d             = 1'b1;
			mem_d             = 1'b1;
			res_d.send_valid  = 1'b1;
			res_d.send_seq    = base_q + SEQ_W'(walk_i_q);
			res_d.is_resend   = 1'b1;
			res_d.timed_out   = 1'b1;
			res_d.window_base = base_q;
			res_d.last        = (walk_i_q == outs[OUTS_W-1:0] - 1'b1);
			walk_i_d          = walk_i_q + 1'b1;
			if (res_d.last) begin
				state_d = ST_RUN;
			end
		end else if (pop) begin
			vld_d             = 1'b1;
			res_d.window_base = base_q;
			res_d.last        = 1'b1;
			case (q_data.cmd)
				CMD_OFFER: begin
					if (outs < SEQ_W'(win_q) && 32'(outs) < RING_DEPTH) begin
						wr_en                = 1'b1;
						next_d               = next_q + 1'b1;
						next_idx_d           = (next_idx_q == IDX_W'(RING_DEPTH - 1)) ?
						                       '0 : next_idx_q + 1'b1;
						if (outs == '0) begin
							tmr_d     = '0;
							tmr_run_d = 1'b1;
						end
						res_d.send_valid     = 1'b1;
						res_d.send_seq       = next_q;
						res_d.send_handle    = q_data.handle;
						res_d.send_length    = q_data.length;
						res_d.offer_accepted = 1'b1;
					end
				end
				CMD_ACK: begin
					if (ack_off < outs) begin
						base_d            = ack_next;
						base_idx_d        = ack_sum[IDX_W-1:0];
						tmr_d             = '0;
						tmr_run_d         = (next_q != ack_next);
						res_d.window_base = ack_next;
					end
				end
				CMD_TICK: begin
					if (tmr_run_q) begin
						tmr_d = tmr_inc;
						if (tmr_inc >= tmo_q && outs != '0) begin
							// expired: drop this slot and walk the window
							tmr_d    = '0;
							state_d  = ST_WALK;
							walk_i_d = '0;
							vld_d    = 1'b0;
						end
					end
				end
				CMD_END: begin
					res_d.send_valid = 1'b1;
					res_d.send_seq   = next_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[next_idx_q] <= '{handle: q_data.handle, length: q_data.length};
		end
		if (rd_en) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	// Merge the ring read into a resend word
	always_comb begin
		res_out = res_s1;
		if (mem_s1) begin
			res_out.send_handle = rd_q.handle;
			res_out.send_length = rd_q.length;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_d;
		mem_s1 <= mem_d;
		result <= res_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			win_q        <= WIN_RESET;
			tmo_q        <= TMO_RESET;
			base_q       <= '0;
			next_q       <= '0;
			base_idx_q   <= '0;
			next_idx_q   <= '0;
			tmr_q        <= '0;
			tmr_run_q    <= 1'b0;
			walk_i_q     <= '0;
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			base_q       <= base_d;
			next_q       <= next_d;
			base_idx_q   <= base_idx_d;
			next_idx_q   <= next_idx_d;
			tmr_q        <= tmr_d;
			tmr_run_q    <= tmr_run_d;
			walk_i_q     <= walk_i_d;
			vld_s1       <= vld_d;
			result_valid <= vld_s1;
			if (cfg_we) begin
				if (cfg_index == CFG_WINDOW) begin
					win_q <= cfg_data[WIN_W-1:0];
				end else if (cfg_index == CFG_TIMEOUT) begin
					tmo_q <= cfg_data[TMR_W-1:0];
				end
			end
		end
	end

	a_walk_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (next_q != base_q))
		else $error("resend walk with empty window");

	a_outs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(outs <= SEQ_W'(15)) && (32'(outs) <= RING_DEPTH))
		else $error("outstanding count beyond window limit");

	a_timer_tracks_window: assert property (@(posedge clk) disable iff (!arst_n)
		tmr_run_q == (next_q != base_q))
		else $error("timer state disagrees with outstanding packets");

	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !res_s1.last) |=> vld_s1)
		else $error("gap inside a resend burst");

endmodule

### rtl/go_back_n_sender_unit.sv
// An offer, ack, tick or end is queued, popped by the back and strobed through res_s1 and result;
// an expiring tick strobes no word itself, and its resends then follow one word per cycle.
// One item per cycle while no resend walk runs; an expiring tick holds the executor for its walk.
// busy rises when the 2-word command queue is full; results cannot be stalled by the receiver.
// Reset (arst_n low) clears window pointers, timer and queue; config returns to window 6,
// timeout 1000. Ring contents are not cleared and are only read after being written.
module go_back_n_sender_unit #(
	parameter int RING_DEPTH  = gbn_pkg::RING_DEPTH_DEF,
	parameter int MAX_PAYLOAD = gbn_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  gbn_pkg::gbn_item_t              item,
	input  logic                            cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            result_valid,
	output gbn_pkg::gbn_result_t            result
);
	import gbn_pkg::*;

	// Front side: take the command word, classify it and clamp the payload length
	gbn_op_t  push_op;
	gbn_op_t  head_op;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;

	gbn_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.op     (push_op)
	);

	// Short queue decouples intake from execution so a resend walk can stall
	// the back while the front still takes words
	gbn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_op),
		.pop    (pop),
		.rdata  (head_op),
		.empty  (q_empty),
		.full   (q_full)
	);

	// Back side: window pointers, packet ring, retransmit timer and resend walk.
	// Each command finishes in one pop; an expiring tick walks the ring one slot
	// a cycle through the memory read port.
	gbn_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_empty      (q_empty),
		.q_data       (head_op),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
